### hdl/dve_pkg.sv
// Shared types and constants of the delta varint encoder.
package dve_pkg;

  // Width of the encoded word and of one varint group
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned DIGIT_W  = 7;
  // Groups per word (ceiling of WORD_W / DIGIT_W) and the padded shift width
  localparam int unsigned NDIGITS  = (WORD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned SR_W     = NDIGITS * DIGIT_W;
  localparam int unsigned PAD_W    = SR_W - WORD_W;
  localparam int unsigned CNT_W    = $clog2(NDIGITS + 1);
  // Bits of the topmost group that carry word bits
  localparam int unsigned TOP_BITS = WORD_W - (NDIGITS - 1) * DIGIT_W;

  localparam logic [CNT_W-1:0]   LAST_DIGIT = CNT_W'(NDIGITS - 1);
  localparam logic [CNT_W-1:0]   MAX_BYTES  = CNT_W'(NDIGITS);
  localparam logic [DIGIT_W-1:0] TOP_MASK   = DIGIT_W'((1 << TOP_BITS) - 1);

  // Sequencer of the serial subtractor
  typedef enum logic [1:0] {
    DU_IDLE,
    DU_RUN,
    DU_DONE
  } du_state_t;

  // Finished word handed from the subtractor to the byte emitter
  typedef struct packed {
    logic [SR_W-1:0]  word;
    logic [CNT_W-1:0] nbytes;
  } dve_word_t;

endpackage

### hdl/dve_delta_unit.sv
// Digit-serial delta subtractor: forms the word to encode one group per cycle.
module dve_delta_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [63:0]            value,
  input  logic                   use_delta,
  input  logic                   restart,
  output logic                   load_ok,
  output logic                   word_valid,
  input  logic                   word_take,
  output dve_pkg::dve_word_t     word_out
);
  import dve_pkg::*;

  du_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   dig_cnt_r;
  logic [SR_W-1:0]    val_r;
  logic [SR_W-1:0]    prev_r;
  logic [SR_W-1:0]    word_r;
  logic [CNT_W-1:0]   nbytes_r;
  logic               delta_r;
  logic               borrow_r;
  logic               step_en;
  logic [DIGIT_W:0]   diff;
  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] prev_in;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DU_IDLE: begin
        if (load) state_nxt = DU_RUN;
      end
      DU_RUN: begin
        if (dig_cnt_r == LAST_DIGIT) state_nxt = DU_DONE;
      end
      DU_DONE: begin
        if (load) state_nxt = DU_RUN;
        else if (word_take) state_nxt = DU_IDLE;
      end
      default: state_nxt = DU_IDLE;
    endcase
  end

  // Outputs of the sequencer; a finished word may leave as the next item enters
  always_comb begin
    load_ok    = 1'b0;
    word_valid = 1'b0;
    step_en    = 1'b0;
    case (state_r)
      DU_IDLE: load_ok = 1'b1;
      DU_RUN:  step_en = 1'b1;
      DU_DONE: begin
        word_valid = 1'b1;
        load_ok    = word_take;
      end
      default: ;
    endcase
  end

  // Subtract one group with borrow; raw items pass the value group through
  always_comb begin
    diff  = {1'b0, val_r[DIGIT_W-1:0]} - {1'b0, prev_r[DIGIT_W-1:0]} - (DIGIT_W+1)'(borrow_r);
    digit = delta_r ? diff[DIGIT_W-1:0] : val_r[DIGIT_W-1:0];
    if (dig_cnt_r == LAST_DIGIT) digit = digit & TOP_MASK;
    // Delta items rotate the new value into the stored one, others keep it
    prev_in = delta_r ? val_r[DIGIT_W-1:0] : prev_r[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= DU_IDLE;
      dig_cnt_r <= '0;
      prev_r    <= '0;
      borrow_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        // Capture the item and clear the stored value on restart
        dig_cnt_r <= '0;
        borrow_r  <= 1'b0;
        if (restart) prev_r <= '0;
      end else if (step_en) begin
        // Advance one group
        dig_cnt_r <= dig_cnt_r + CNT_W'(1);
        borrow_r  <= diff[DIGIT_W];
        prev_r    <= {prev_in, prev_r[SR_W-1:DIGIT_W]};
      end
    end
  end

  // Payload shift registers
  always_ff @(posedge clk) begin
    if (load) begin
      val_r    <= {{PAD_W{1'b0}}, value};
      delta_r  <= use_delta;
      nbytes_r <= CNT_W'(1);
    end else if (step_en) begin
      val_r  <= {{DIGIT_W{1'b0}}, val_r[SR_W-1:DIGIT_W]};
      word_r <= {digit, word_r[SR_W-1:DIGIT_W]};
      if (digit != '0) nbytes_r <= dig_cnt_r + CNT_W'(1);
    end
  end

  assign word_out.word   = word_r;
  assign word_out.nbytes = nbytes_r;

  // The group counter never runs past the last group while stepping
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DU_RUN) |-> (dig_cnt_r <= LAST_DIGIT)) else $error("group counter out of range");

  // A finished word is fully consumed from the value register
  a_val_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DU_DONE) |-> (val_r == '0)) else $error("value not drained");

  // A finished word asks for between one and the maximum number of bytes
  a_nbytes: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid |-> (nbytes_r != '0 && nbytes_r <= MAX_BYTES))
    else $error("byte count out of range");

  // The last step always ends in the finished state
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DU_RUN && dig_cnt_r == LAST_DIGIT) |=> (state_r == DU_DONE))
    else $error("run did not finish");

endmodule

### hdl/dve_emitter.sv
// Byte emitter: shifts a finished word out as LEB128 bytes, one per transaction.
module dve_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               word_valid,
  input  dve_pkg::dve_word_t word_in,
  output logic               word_take,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);
  import dve_pkg::*;

  logic [SR_W-1:0]  sr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_fire;

  assign out_tvalid = (cnt_r != '0);
  assign out_fire   = out_tvalid && out_tready;
  assign word_take  = word_valid && (cnt_r == '0);
  assign out_tlast  = (cnt_r == CNT_W'(1));
  // Continuation flag set on every byte but the last
  assign out_tdata  = {~out_tlast, sr_r[DIGIT_W-1:0]};

  // Byte count: load a new word when empty, count down per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (word_take) begin
      cnt_r <= word_in.nbytes;
    end else if (out_fire) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Group shift register
  always_ff @(posedge clk) begin
    if (word_take) begin
      sr_r <= word_in.word;
    end else if (out_fire) begin
      sr_r <= {{DIGIT_W{1'b0}}, sr_r[SR_W-1:DIGIT_W]};
    end
  end

  // The count never exceeds the longest encoding
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_BYTES) else $error("byte count overflow");

  // A taken word always produces at least one byte
  a_take_emits: assert property (@(posedge clk) disable iff (!rst_n)
    word_take |=> out_tvalid) else $error("taken word produced no byte");

  // A stalled byte keeps its count
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (cnt_r == $past(cnt_r)))
    else $error("count moved while stalled");

endmodule

### hdl/delta_varint_encoder.sv
// Top level of the delta varint encoder.
//
// Input channel in_*: one transaction carries a 64-bit value in in_tdata and
// the flags use_delta and restart in in_tuser. restart clears the stored
// previous value before encoding; use_delta encodes value minus previous
// (modulo 2^64) and stores value, otherwise the value is encoded raw.
// Output channel out_*: one transaction per encoded byte, least significant
// 7-bit group first, bit 7 set on every byte but the last; out_tlast marks
// the final byte of an item. A zero word gives the single byte 0.
// Operation: the subtractor works one 7-bit group per cycle over the ten
// groups of a word; the finished word then passes to the emitter, which
// drives out_tvalid from its registered byte count.
// Overlap: an item gives 1 to 10 bytes; the serial subtractor works on the
// next item while the emitter sends the bytes of the current one.
// Reset (rst_n low, synchronous) clears the previous value and drops any
// item in flight. When the receiver stalls, the current byte holds on
// out_tdata; one finished word waits, and in_tready falls until it moves on.
module delta_varint_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  input  logic [1:0]  in_tuser,   // [0] use_delta, [1] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] byte_out
  output logic        out_tlast
);
  import dve_pkg::*;

  logic      load;
  logic      load_ok;
  logic      word_valid;
  logic      word_take;
  dve_word_t word;

  assign in_tready = load_ok;
  assign load      = in_tvalid && load_ok;

  dve_delta_unit u_delta (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .value      (in_tdata),
    .use_delta  (in_tuser[0]),
    .restart    (in_tuser[1]),
    .load_ok    (load_ok),
    .word_valid (word_valid),
    .word_take  (word_take),
    .word_out   (word)
  );

  dve_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word_in    (word),
    .word_take  (word_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
